@@ hw/rtl/pst_pkg.sv @@
// ============================================================================
// pst_pkg - shared types and constants of the pascal subset tokenizer
// token kinds, scanner modes, result layout and the reserved word table
// ============================================================================
`default_nettype none

package pst_pkg;

    // token kinds as reported on the result channel
    typedef enum logic [3:0] {
        KIND_ASSIGN       = 4'd0,
        KIND_REAL         = 4'd1,
        KIND_BOOL         = 4'd2,
        KIND_NOT          = 4'd3,
        KIND_REL          = 4'd4,
        KIND_ADD          = 4'd5,
        KIND_MUL          = 4'd6,
        KIND_RESERVED     = 4'd7,
        KIND_DELIM        = 4'd8,
        KIND_IDENT        = 4'd9,
        KIND_INT          = 4'd10,
        KIND_UNKNOWN      = 4'd11,
        KIND_OPEN_COMMENT = 4'd12
    } kind_t;

    // what the pending token is
    typedef enum logic [9:0] {
        MODE_IDLE    = 10'b00_0000_0001,
        MODE_WORD    = 10'b00_0000_0010,
        MODE_INT     = 10'b00_0000_0100,
        MODE_FRAC    = 10'b00_0000_1000,
        MODE_DOT     = 10'b00_0001_0000,
        MODE_DOTREAL = 10'b00_0010_0000,
        MODE_COLON   = 10'b00_0100_0000,
        MODE_LESS    = 10'b00_1000_0000,
        MODE_GREATER = 10'b01_0000_0000,
        MODE_SLASH   = 10'b10_0000_0000
    } mode_t;

    localparam int WIDX_W     = 5;
    localparam int LINE_W     = 16;
    localparam int COL_W      = 12;
    localparam int LEN_OUT_W  = 8;
    localparam int SYM_W      = 8;
    localparam int TDATA_W    = 56;
    localparam int FIFO_DEPTH = 4;

    // result payload, first field in the highest bits
    typedef struct packed {
        logic [SYM_W-1:0]     symbol;
        logic [LEN_OUT_W-1:0] length;
        logic [COL_W-1:0]     column;
        logic [LINE_W-1:0]    line;
        logic [WIDX_W-1:0]    word_index;
    } token_data_t;

    typedef struct packed {
        kind_t       kind;
        logic        last;
        token_data_t data;
    } token_t;

    // reserved words and word operators, right-justified text
    localparam int NUM_WORDS      = 19;
    localparam int WORD_CHARS_MAX = 9;

    localparam logic [8*WORD_CHARS_MAX-1:0] WORD_TEXT [NUM_WORDS] = '{
        "program", "var", "integer", "real", "boolean", "procedure", "begin",
        "end", "if", "then", "else", "while", "do", "endif", "true", "false",
        "not", "or", "and"
    };

    localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
        4'd7, 4'd3, 4'd7, 4'd4, 4'd7, 4'd9, 4'd5, 4'd3, 4'd2, 4'd4,
        4'd4, 4'd5, 4'd2, 4'd5, 4'd4, 4'd5, 4'd3, 4'd2, 4'd3
    };

    localparam kind_t WORD_KIND [NUM_WORDS] = '{
        KIND_RESERVED, KIND_RESERVED, KIND_RESERVED, KIND_RESERVED, KIND_RESERVED,
        KIND_RESERVED, KIND_RESERVED, KIND_RESERVED, KIND_RESERVED, KIND_RESERVED,
        KIND_RESERVED, KIND_RESERVED, KIND_RESERVED, KIND_RESERVED, KIND_BOOL,
        KIND_BOOL, KIND_NOT, KIND_ADD, KIND_MUL
    };

endpackage

`default_nettype wire

@@ hw/rtl/pascal_subset_tokenizer_unit.sv @@
// ============================================================================
// pascal_subset_tokenizer_unit - streaming lexer for a small pascal dialect
// one source byte per word in, classified tokens with position out
// ============================================================================
// The unit takes one source byte per cycle and scans it in a single pass
// against the held token state; each byte yields zero, one or two tokens,
// which go into a four-entry result queue. Input is taken every cycle while
// the queue has room for two tokens, so the input rate is one byte per cycle
// as long as the consumer takes about one token per cycle; the output port
// moves one token per cycle, so a byte that closes one token and yields
// another needs two output transfers. Each token is written into the result
// queue when the byte that yields it is accepted. The end-of-input command
// flushes the pending token, reports an open brace comment and returns all
// scan state to its reset values. No clearing pass is needed after reset.
`default_nettype none

module pascal_subset_tokenizer_unit
    import pst_pkg::*;
#(
    parameter int KEYWORD_CHARS = 9,
    parameter int MAX_TOKEN_LEN = 255,
    parameter int LINE_BITS     = 16,
    parameter int COLUMN_BITS   = 12
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // character
    input  wire logic [0:0]         s_tuser,   // command
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // word_index, line, column, length, symbol
    output logic [3:0]              m_tuser,   // kind
    output logic                    m_tlast
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int KW    = $clog2(KEYWORD_CHARS);
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // scan state
    mode_t                  mode_reg, mode_next;
    logic                   brace_reg, brace_next;
    logic                   lcom_reg, lcom_next;
    logic [LEN_W-1:0]       tlen_reg, tlen_next;
    logic [COLUMN_BITS-1:0] tcol_reg, tcol_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [7:0]             psym_reg, psym_next;
    logic [7:0]             word_buf_reg [KEYWORD_CHARS];

    logic                   buf_we;
    logic [KW-1:0]          buf_idx;

    // result queue
    token_t                 fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]       wptr_reg, wptr_next;
    logic [PTR_W-1:0]       rptr_reg, rptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PTR_W-1:0]       wptr_inc;

    logic                   in_acc;
    logic                   out_acc;
    logic                   cmd_end;
    logic [7:0]             c;

    logic                   word_hit;
    kind_t                  word_kind;
    logic [WIDX_W-1:0]      word_idx;

    token_t                 res0, res1, first_res;
    logic                   v0, v1;
    logic [LEN_W-1:0]       tlen_app;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign cmd_end = s_tuser[0];
    assign c       = s_tdata;

    assign tlen_app = (32'(tlen_reg) < MAX_TOKEN_LEN) ? tlen_reg + LEN_W'(1) : tlen_reg;

    function automatic logic [LINE_W-1:0] line_out(input logic [LINE_BITS-1:0] l);
        logic [31:0] ext;
        ext = 32'(l);
        return ext[LINE_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] col_out(input logic [COLUMN_BITS-1:0] v);
        logic [23:0] ext;
        ext = 24'(v);
        return ext[COL_W-1:0];
    endfunction

    function automatic logic [LEN_OUT_W-1:0] len_out(input logic [LEN_W-1:0] l);
        logic [15:0] ext;
        ext = 16'(l);
        return (ext > 16'd255) ? 8'hFF : ext[LEN_OUT_W-1:0];
    endfunction

    function automatic token_t make_token(
        input kind_t                  kind,
        input logic [WIDX_W-1:0]      widx,
        input logic [LINE_W-1:0]      ln,
        input logic [COL_W-1:0]       cl,
        input logic [LEN_OUT_W-1:0]   len,
        input logic [SYM_W-1:0]       sym
    );
        token_t t;
        t.kind            = kind;
        t.last            = 1'b0;
        t.data.word_index = widx;
        t.data.line       = ln;
        t.data.column     = cl;
        t.data.length     = len;
        t.data.symbol     = sym;
        return t;
    endfunction

    // whole-word compare against every table entry at once
    always_comb
    begin : word_match
        logic [8*WORD_CHARS_MAX-1:0] txt;
        logic                        eq;
        word_hit  = 1'b0;
        word_kind = KIND_IDENT;
        word_idx  = '0;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            // left-justify so byte j sits at a fixed place
            txt = WORD_TEXT[i] << (8 * (WORD_CHARS_MAX - int'(WORD_LEN[i])));
            eq  = (32'(tlen_reg) == int'(WORD_LEN[i]));
            for (int j = 0; j < WORD_CHARS_MAX; j++)
            begin
                if (j < int'(WORD_LEN[i]) &&
                    word_buf_reg[j] != txt[8*(WORD_CHARS_MAX-1-j) +: 8])
                begin
                    eq = 1'b0;
                end
            end
            if (eq)
            begin
                word_hit  = 1'b1;
                word_kind = WORD_KIND[i];
                word_idx  = WIDX_W'(i + 1);
            end
        end
    end

    // the pending token as it would be emitted on a flush
    token_t pend;
    always_comb
    begin
        kind_t             k;
        logic [WIDX_W-1:0] wi;
        wi = '0;
        case (mode_reg)
            MODE_WORD:
            begin
                k  = word_hit ? word_kind : KIND_IDENT;
                wi = word_hit ? word_idx : '0;
            end
            MODE_INT:                   k = KIND_INT;
            MODE_FRAC, MODE_DOTREAL:    k = KIND_REAL;
            MODE_DOT, MODE_COLON:       k = KIND_DELIM;
            MODE_LESS, MODE_GREATER:    k = KIND_REL;
            MODE_SLASH:                 k = KIND_MUL;
            default:                    k = KIND_UNKNOWN;
        endcase
        pend = make_token(k, wi, line_out(line_reg), col_out(tcol_reg),
                          len_out(tlen_reg), psym_reg);
    end

    // single-pass scan of one byte
    always_comb
    begin
        logic  absorb;
        logic  start;
        mode_t start_mode;

        mode_next  = mode_reg;
        brace_next = brace_reg;
        lcom_next  = lcom_reg;
        tlen_next  = tlen_reg;
        tcol_next  = tcol_reg;
        col_next   = col_reg;
        line_next  = line_reg;
        psym_next  = psym_reg;
        buf_we     = 1'b0;
        buf_idx    = tlen_reg[KW-1:0];
        v0         = 1'b0;
        v1         = 1'b0;
        res0       = pend;
        res1       = pend;
        absorb     = 1'b0;
        start      = 1'b0;
        start_mode = MODE_IDLE;

        if (cmd_end)
        begin
            if (mode_reg != MODE_IDLE && !(mode_reg == MODE_SLASH && brace_reg))
            begin
                v0 = 1'b1;
            end
            if (brace_reg)
            begin
                v1   = 1'b1;
                res1 = make_token(KIND_OPEN_COMMENT, '0, line_out(line_reg),
                                  col_out(col_reg), 8'd1, "{");
            end
            mode_next  = MODE_IDLE;
            brace_next = 1'b0;
            lcom_next  = 1'b0;
            tlen_next  = '0;
            tcol_next  = '0;
            col_next   = '0;
            line_next  = LINE_BITS'(1);
            psym_next  = '0;
        end
        else
        begin
            if (lcom_reg)
            begin
                if (c == "\n")
                begin
                    lcom_next = 1'b0;
                end
            end
            else if (brace_reg)
            begin
                if (mode_reg == MODE_SLASH && c == "/")
                begin
                    lcom_next = 1'b1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                    if (c == "}")
                    begin
                        brace_next = 1'b0;
                    end
                    else if (c == "/")
                    begin
                        mode_next = MODE_SLASH;
                    end
                end
            end
            else
            begin
                // offer the byte to the pending token
                case (mode_reg)
                    MODE_WORD:
                    begin
                        absorb = c inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"};
                    end
                    MODE_INT:
                    begin
                        absorb = c inside {["0":"9"], "."};
                        if (c == ".")
                        begin
                            mode_next = MODE_FRAC;
                        end
                    end
                    MODE_FRAC, MODE_DOTREAL:
                    begin
                        absorb = c inside {["0":"9"]};
                    end
                    MODE_DOT:
                    begin
                        absorb = c inside {["0":"9"]};
                        if (absorb)
                        begin
                            mode_next = MODE_DOTREAL;
                        end
                    end
                    MODE_COLON:
                    begin
                        absorb = (c == "=");
                        if (absorb)
                        begin
                            v0        = 1'b1;
                            res0      = make_token(KIND_ASSIGN, '0, line_out(line_reg),
                                                   col_out(tcol_reg), len_out(tlen_app),
                                                   psym_reg);
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_LESS:
                    begin
                        absorb = c inside {"=", ">"};
                        if (absorb)
                        begin
                            v0        = 1'b1;
                            res0      = make_token(KIND_REL, '0, line_out(line_reg),
                                                   col_out(tcol_reg), len_out(tlen_app),
                                                   psym_reg);
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_GREATER:
                    begin
                        absorb = (c == "=");
                        if (absorb)
                        begin
                            v0        = 1'b1;
                            res0      = make_token(KIND_REL, '0, line_out(line_reg),
                                                   col_out(tcol_reg), len_out(tlen_app),
                                                   psym_reg);
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_SLASH:
                    begin
                        absorb = (c == "/");
                        if (absorb)
                        begin
                            mode_next = MODE_IDLE;
                            lcom_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        absorb = 1'b0;
                    end
                endcase

                if (absorb && mode_reg != MODE_SLASH)
                begin
                    buf_we    = (32'(tlen_reg) < KEYWORD_CHARS);
                    tlen_next = tlen_app;
                end

                if (!absorb)
                begin
                    // token ended by this byte
                    if (mode_reg != MODE_IDLE)
                    begin
                        v0 = 1'b1;
                    end
                    mode_next = MODE_IDLE;

                    if (c inside {"\n", " ", "\t"})
                    begin
                        start = 1'b0;
                    end
                    else if (c == "{")
                    begin
                        brace_next = 1'b1;
                    end
                    else if (c inside {["a":"z"], ["A":"Z"]})
                    begin
                        start      = 1'b1;
                        start_mode = MODE_WORD;
                    end
                    else if (c inside {["0":"9"]})
                    begin
                        start      = 1'b1;
                        start_mode = MODE_INT;
                    end
                    else
                    begin
                        case (c)
                            ".":
                            begin
                                start      = 1'b1;
                                start_mode = MODE_DOT;
                            end
                            ":":
                            begin
                                start      = 1'b1;
                                start_mode = MODE_COLON;
                            end
                            "<":
                            begin
                                start      = 1'b1;
                                start_mode = MODE_LESS;
                            end
                            ">":
                            begin
                                start      = 1'b1;
                                start_mode = MODE_GREATER;
                            end
                            "/":
                            begin
                                start      = 1'b1;
                                start_mode = MODE_SLASH;
                            end
                            ";", "(", ")", ",":
                            begin
                                v1   = 1'b1;
                                res1 = make_token(KIND_DELIM, '0, line_out(line_reg),
                                                  col_out(col_reg), 8'd1, c);
                            end
                            "=":
                            begin
                                v1   = 1'b1;
                                res1 = make_token(KIND_REL, '0, line_out(line_reg),
                                                  col_out(col_reg), 8'd1, c);
                            end
                            "+", "-":
                            begin
                                v1   = 1'b1;
                                res1 = make_token(KIND_ADD, '0, line_out(line_reg),
                                                  col_out(col_reg), 8'd1, c);
                            end
                            "*":
                            begin
                                v1   = 1'b1;
                                res1 = make_token(KIND_MUL, '0, line_out(line_reg),
                                                  col_out(col_reg), 8'd1, c);
                            end
                            default:
                            begin
                                v1   = 1'b1;
                                res1 = make_token(KIND_UNKNOWN, '0, line_out(line_reg),
                                                  col_out(col_reg), 8'd1, c);
                            end
                        endcase
                    end

                    if (start)
                    begin
                        mode_next = start_mode;
                        tcol_next = col_reg;
                        tlen_next = LEN_W'(1);
                        psym_next = c;
                        buf_we    = 1'b1;
                        buf_idx   = '0;
                    end
                end
            end

            // position update
            if (c == "\n")
            begin
                if (brace_next)
                begin
                    mode_next = MODE_IDLE;
                end
                if (line_reg != '1)
                begin
                    line_next = line_reg + LINE_BITS'(1);
                end
                col_next = '0;
            end
            else if (col_reg != '1)
            begin
                col_next = col_reg + COLUMN_BITS'(1);
            end
        end

        res0.last = !v1;
        res1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            brace_reg <= 1'b0;
            lcom_reg  <= 1'b0;
            tlen_reg  <= '0;
            tcol_reg  <= '0;
            col_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
            psym_reg  <= '0;
        end
        else if (in_acc)
        begin
            mode_reg  <= mode_next;
            brace_reg <= brace_next;
            lcom_reg  <= lcom_next;
            tlen_reg  <= tlen_next;
            tcol_reg  <= tcol_next;
            col_reg   <= col_next;
            line_reg  <= line_next;
            psym_reg  <= psym_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && buf_we)
        begin
            word_buf_reg[buf_idx] <= c;
        end
    end

    // result queue: up to two writes, one read per cycle
    assign first_res = v0 ? res0 : res1;
    assign wptr_inc  = wptr_reg + PTR_W'(1);

    always_comb
    begin
        logic [1:0] push;
        push = 2'd0;
        if (in_acc)
        begin
            push = {1'b0, v0} + {1'b0, v1};
        end
        wptr_next  = wptr_reg + PTR_W'(push);
        rptr_next  = out_acc ? rptr_reg + PTR_W'(1) : rptr_reg;
        count_next = count_reg + CNT_W'(push) - CNT_W'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (v0 || v1))
        begin
            fifo_reg[wptr_reg] <= first_res;
        end
        if (in_acc && v0 && v1)
        begin
            fifo_reg[wptr_inc] <= res1;
        end
    end

    assign s_tready = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{(TDATA_W - $bits(token_data_t)){1'b0}}, fifo_reg[rptr_reg].data};
    assign m_tuser  = fifo_reg[rptr_reg].kind;
    assign m_tlast  = fifo_reg[rptr_reg].last;

`ifndef ASSERT_OFF
    // a line comment never holds a pending token
    assert property (@(posedge clk) disable iff (!rst_n)
        lcom_reg |-> (mode_reg == MODE_IDLE))
        else $error("pending token inside a line comment");

    // inside a brace comment only a possible comment opener is held
    assert property (@(posedge clk) disable iff (!rst_n)
        brace_reg |-> (mode_reg == MODE_IDLE || mode_reg == MODE_SLASH))
        else $error("pending token inside a brace comment");

    // end of input returns the scanner to its start state
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && cmd_end) |=> (line_reg == LINE_BITS'(1) && !brace_reg &&
                                 !lcom_reg && col_reg == '0))
        else $error("scan state not cleared after end of input");

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");
`endif

endmodule

`default_nettype wire
